FILE: sv/ccb_pkg.sv
// shared constants for the character cell buffer
package ccb_pkg;

  localparam int CHAR_W = 8;
  localparam int OP_W   = 3;
  localparam int COORD_W = 16;

  // command codes
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_RAW  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_DISP = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL      = 3'd3;
  localparam logic [OP_W-1:0] OP_LOCK_AREA = 3'd4;
  localparam logic [OP_W-1:0] OP_CAPTURE   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;
  // code outside the command set, leaves all state alone
  localparam logic [OP_W-1:0] OP_RESERVED  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  localparam logic [7:0] COLS_RESET = 8'd128;
  localparam logic [6:0] ROWS_RESET = 7'd64;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'h00;

endpackage

FILE: sv/char_cell_buffer_with_locks.sv
// character cell frame buffer with background and per-cell locks
//
// A single-cell command (write, read raw, read displayed) goes from accept to result
// through operand clamp, one pass through the shared address multiplier, a
// registered memory read and the execute step. Fill and capture sweep the active
// area at one cell per cycle, lock area writes one cell per cycle over the clamped
// rectangle and writes nothing when the rectangle is empty, and clear sweeps all
// MAX_COLS * MAX_ROWS cells; each cell store has a single write port.
// After reset the block runs a clearing pass over all MAX_COLS * MAX_ROWS cells
// before it takes the first command; configuration writes are taken at any time.
module char_cell_buffer_with_locks #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] opcode, [18:3] col, [34:19] row, [50:35] col_end, [66:51] row_end,
  // [74:67] char_value, [75] lock_value, [79:76] zero
  input  logic [79:0] in_tdata,
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] char_out, [10:8] command_done, [15:11] zero
  output logic [15:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW = $clog2(NUM_CELLS);
  localparam int MW = RW + CW;
  localparam int CHW = ccb_pkg::CHAR_W;
  localparam int OPW = ccb_pkg::OP_W;
  localparam logic [AW-1:0] LAST_CELL = AW'(NUM_CELLS - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ADDR  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_EXEC  = 4'd3;
  localparam logic [3:0] ST_SWEEP = 4'd4;
  localparam logic [3:0] ST_DRAIN = 4'd5;
  localparam logic [3:0] ST_LOCK  = 4'd6;
  localparam logic [3:0] ST_CLR   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic           init_r, init_nxt;
  logic [7:0]     cols_r, cols_nxt;
  logic [6:0]     rows_r, rows_nxt;
  logic [OPW-1:0] op_r, op_nxt;
  logic [CW-1:0]  x_r, x_nxt, ex_r, ex_nxt, cx_r, cx_nxt;
  logic [RW-1:0]  y_r, y_nxt, ey_r, ey_nxt, cy_r, cy_nxt;
  logic [CHW-1:0] ch_r, ch_nxt;
  logic           lk_r, lk_nxt;
  logic [AW-1:0]  addr_r, addr_nxt, rs_r, rs_nxt, cnt_r, cnt_nxt, last_r, last_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CHW-1:0] res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CHW-1:0] out_char_r, out_char_nxt;
  logic [OPW-1:0] out_op_r, out_op_nxt;

  logic [CW-1:0]  nc;
  logic [RW-1:0]  nr;
  logic           in_acc;
  logic [OPW-1:0] in_op;

  // active sizes, out-of-range register values pulled into 1..max
  always_comb begin
    if (cols_r == 8'd0) begin
      nc = CW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cols_r);
    end
    if (rows_r == 7'd0) begin
      nr = RW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_r);
    end
  end

  // clamp a signed coordinate into 1..lim
  function automatic logic [CW-1:0] clamp_col(logic signed [15:0] v, logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if ($signed(v) > $signed({1'b0, lim})) begin
      r = lim;
    end else if ($signed(v) <= 0) begin
      r = CW'(1);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] clamp_row(logic signed [15:0] v, logic [RW-1:0] lim);
    logic [RW-1:0] r;
    if ($signed(v) > $signed({1'b0, lim})) begin
      r = lim;
    end else if ($signed(v) <= 0) begin
      r = RW'(1);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  // shared address unit: (row - 1) * columns + (col - 1)
  logic [CW-1:0] mul_x;
  logic [RW-1:0] mul_y;
  logic [MW-1:0] mul_full;
  logic [AW-1:0] mul_addr;

  always_comb begin
    if (op_r == ccb_pkg::OP_FILL || op_r == ccb_pkg::OP_CAPTURE) begin
      mul_x = nc;
      mul_y = nr;
    end else begin
      mul_x = x_r;
      mul_y = y_r;
    end
  end

  assign mul_full = MW'(mul_y - RW'(1)) * MW'(nc) + MW'(mul_x - CW'(1));
  assign mul_addr = mul_full[AW-1:0];

  // cell stores
  logic           cw_en, bw_en, lw_en;
  logic [AW-1:0]  cw_addr, bw_addr, lw_addr, rd_addr;
  logic [CHW-1:0] cw_data, bw_data;
  logic           lw_data;
  logic [CHW-1:0] char_q, bg_q;
  logic           lock_q;
  logic [CHW-1:0] disp_q;
  logic           clr_now;

  assign clr_now = (state_r == ST_CLR);
  assign rd_addr = (state_r == ST_SWEEP) ? cnt_r : addr_r;
  assign disp_q  = (char_q != ccb_pkg::EMPTY_CHAR) ? char_q : bg_q;

  assign cw_en = clr_now
      || (state_r == ST_EXEC && op_r == ccb_pkg::OP_WRITE && !lock_q)
      || (pend_r && op_r == ccb_pkg::OP_FILL && !lock_q);
  assign cw_addr = clr_now ? cnt_r : (pend_r ? pend_addr_r : addr_r);
  assign cw_data = clr_now ? ccb_pkg::EMPTY_CHAR : ch_r;

  assign bw_en   = clr_now || (pend_r && op_r == ccb_pkg::OP_CAPTURE);
  assign bw_addr = clr_now ? cnt_r : pend_addr_r;
  assign bw_data = clr_now ? ccb_pkg::SPACE_CHAR : disp_q;

  assign lw_en   = clr_now || (state_r == ST_LOCK);
  assign lw_addr = clr_now ? cnt_r : addr_r;
  assign lw_data = clr_now ? 1'b0 : lk_r;

  ccb_ram #(.WIDTH(CHW), .DEPTH(NUM_CELLS)) u_char_ram (
    .clk(clk), .we(cw_en), .waddr(cw_addr), .wdata(cw_data),
    .raddr(rd_addr), .rdata(char_q)
  );

  ccb_ram #(.WIDTH(CHW), .DEPTH(NUM_CELLS)) u_bg_ram (
    .clk(clk), .we(bw_en), .waddr(bw_addr), .wdata(bw_data),
    .raddr(rd_addr), .rdata(bg_q)
  );

  ccb_ram #(.WIDTH(1), .DEPTH(NUM_CELLS)) u_lock_ram (
    .clk(clk), .we(lw_en), .waddr(lw_addr), .wdata(lw_data),
    .raddr(rd_addr), .rdata(lock_q)
  );

  // handshakes
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_op      = in_tdata[2:0];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_op_r, out_char_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ch_nxt        = ch_r;
    lk_nxt        = lk_r;
    addr_nxt      = addr_r;
    rs_nxt        = rs_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_op_nxt    = out_op_r;

    // configuration registers
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == ccb_pkg::CFG_COLUMNS) begin
        cols_nxt = cfg_data;
      end else if (cfg_index == ccb_pkg::CFG_ROWS) begin
        rows_nxt = cfg_data[6:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_op;
          x_nxt   = clamp_col($signed(in_tdata[18:3]), nc);
          y_nxt   = clamp_row($signed(in_tdata[34:19]), nr);
          ex_nxt  = clamp_col($signed(in_tdata[50:35]), nc);
          ey_nxt  = clamp_row($signed(in_tdata[66:51]), nr);
          ch_nxt  = in_tdata[74:67];
          lk_nxt  = in_tdata[75];
          res_nxt = ccb_pkg::EMPTY_CHAR;
          cnt_nxt = '0;
          if (in_op == ccb_pkg::OP_CLEAR) begin
            state_nxt = ST_CLR;
          end else if (in_op == ccb_pkg::OP_RESERVED) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        addr_nxt = mul_addr;
        rs_nxt   = mul_addr;
        last_nxt = mul_addr;
        cx_nxt   = x_r;
        cy_nxt   = y_r;
        case (op_r)
          ccb_pkg::OP_FILL, ccb_pkg::OP_CAPTURE: state_nxt = ST_SWEEP;
          ccb_pkg::OP_LOCK_AREA: begin
            // empty rectangle leaves every lock alone
            if (x_r > ex_r || y_r > ey_r) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_LOCK;
            end
          end
          default: state_nxt = ST_RD;
        endcase
      end
      ST_RD: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == ccb_pkg::OP_READ_RAW) begin
          res_nxt = char_q;
        end else if (op_r == ccb_pkg::OP_READ_DISP) begin
          res_nxt = disp_q;
        end
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        // read cell cnt now, write it back in the following cycle
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        if (cnt_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_LOCK: begin
        // walk the rectangle row by row
        if (cx_r == ex_r) begin
          if (cy_r == ey_r) begin
            state_nxt = ST_DONE;
          end else begin
            cy_nxt   = cy_r + RW'(1);
            cx_nxt   = x_r;
            rs_nxt   = rs_r + AW'(nc);
            addr_nxt = rs_r + AW'(nc);
          end
        end else begin
          cx_nxt   = cx_r + CW'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_CLR: begin
        if (cnt_r == LAST_CELL) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = res_r;
          out_op_nxt    = op_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= ccb_pkg::COLS_RESET;
      rows_r      <= ccb_pkg::ROWS_RESET;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    ch_r        <= ch_nxt;
    lk_r        <= lk_nxt;
    addr_r      <= addr_nxt;
    rs_r        <= rs_nxt;
    last_r      <= last_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
    out_char_r  <= out_char_nxt;
    out_op_r    <= out_op_nxt;
  end

  // one command in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in flight");

  // the sweep counter never runs past the last active cell
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> cnt_r <= last_r)
    else $error("sweep ran past the active area");

  // lock walking never touches cell or background characters
  a_lock_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOCK |-> !cw_en && !bw_en)
    else $error("character store written during lock area");

  // only the read commands return a character
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] != ccb_pkg::OP_READ_RAW
      && out_tdata[10:8] != ccb_pkg::OP_READ_DISP |-> out_tdata[7:0] == 8'd0)
    else $error("non-read command returned a character");

endmodule

FILE: sv/ccb_ram.sv
// generic single write port ram with registered read
module ccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/char_cell_buffer_with_locks_test.sv
// self-checking testbench for the character cell buffer with per-cell locks
`timescale 1ns / 1ps

module char_cell_buffer_with_locks_test;

  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 64;
  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;

  localparam int CHAR_W  = ccb_pkg::CHAR_W;
  localparam int OP_W    = ccb_pkg::OP_W;
  localparam int COORD_W = ccb_pkg::COORD_W;

  localparam int PHASE_COUNT     = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 20;
  // a few dozen full sweeps, about 2k single-cell words with gaps and stalls, the
  // clearing pass after reset and the long hold all fit well within this limit
  localparam int CYCLE_LIMIT     = 2_000_000;

  // register values per phase: extremes, zero and out-of-range sizes among them
  localparam int PHASE_COLS [PHASE_COUNT] = '{4, 1, 0, 16, 255, 128, 7, 10, 33, 2};
  localparam int PHASE_ROWS [PHASE_COUNT] = '{3, 1, 0, 8, 255, 64, 5, 100, 17, 64};

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_end;
    logic [CHAR_W-1:0]  ch;
    logic               lk;
  } frame_cmd_t;

  typedef struct packed {
    frame_cmd_t        cmd;
    logic              typed;
    logic [CHAR_W-1:0] want;
  } directed_row_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [OP_W-1:0]   op;
  } frame_reply_t;

  // directed words at the reset size of 128 x 64; typed results only where obvious
  localparam int DIRECTED_COUNT = 25;
  localparam directed_row_t DIRECTED [DIRECTED_COUNT] = '{
    '{'{ccb_pkg::OP_READ_RAW,  16'd1, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h00},
    '{'{ccb_pkg::OP_READ_DISP, 16'd1, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h20},
    '{'{ccb_pkg::OP_WRITE,     16'd1, 16'd1, 16'd0, 16'd0, 8'h41, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd1, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_WRITE, 16'h8000, 16'h8000, 16'd0, 16'd0, 8'hFF, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_WRITE, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 8'h80, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd128, 16'd64, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h80},
    '{'{ccb_pkg::OP_READ_DISP, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'hFF},
    '{'{ccb_pkg::OP_LOCK_AREA, 16'd1, 16'd1, 16'd2, 16'd2, 8'h00, 1'b1}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_WRITE,     16'd1, 16'd1, 16'd0, 16'd0, 8'h11, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd1, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_LOCK_AREA, 16'd5, 16'd5, 16'd3, 16'd9, 8'h00, 1'b1}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_WRITE,     16'd5, 16'd5, 16'd0, 16'd0, 8'h55, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd5, 16'd5, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_FILL,      16'd0, 16'd0, 16'd0, 16'd0, 8'h2A, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd2, 16'd2, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_WRITE,     16'd3, 16'd3, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_DISP, 16'd3, 16'd3, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h20},
    '{'{ccb_pkg::OP_CAPTURE,   16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_LOCK_AREA,
        16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_DISP, 16'd3, 16'd3, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_RESERVED,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}, 1'b1, 8'h00},
    '{'{ccb_pkg::OP_CLEAR,     16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b0, 8'h00},
    '{'{ccb_pkg::OP_READ_RAW,  16'd128, 16'd64, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h00},
    '{'{ccb_pkg::OP_READ_DISP, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 8'h00, 1'b0}, 1'b1, 8'h20}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = ccb_pkg::CFG_COLUMNS;
  logic [7:0]  cfg_data = '0;

  // mirror of the frame stores and size registers
  logic [CHAR_W-1:0] glyph_store [NUM_CELLS];
  logic [CHAR_W-1:0] backdrop_store [NUM_CELLS];
  logic              lock_store [NUM_CELLS];
  logic [7:0]        cols_setting;
  logic [6:0]        rows_setting;

  frame_reply_t pending_replies [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  logic         hold_results = 1'b0;
  event         hold_go;

  char_cell_buffer_with_locks #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stores back to their power-on contents
  function automatic void wipe_frame();
    for (int i = 0; i < NUM_CELLS; i++) begin
      glyph_store[i] = ccb_pkg::EMPTY_CHAR;
      backdrop_store[i] = ccb_pkg::SPACE_CHAR;
      lock_store[i] = 1'b0;
    end
  endfunction

  function automatic int active_width();
    int w;
    w = cols_setting;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = rows_setting;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic int fit_coord(logic signed [COORD_W-1:0] v, int lim);
    int t;
    t = v;
    if (t > lim) t = lim;
    if (t <= 0) t = 1;
    return t;
  endfunction

  function automatic int cell_addr(int x, int y, int w);
    return ((x - 1) + (y - 1) * w) % NUM_CELLS;
  endfunction

  // empty cells show the background
  function automatic logic [CHAR_W-1:0] visible_char(int a);
    return (glyph_store[a] != ccb_pkg::EMPTY_CHAR) ? glyph_store[a] : backdrop_store[a];
  endfunction

  // applies one command to the mirror, returns the character it reads
  function automatic logic [CHAR_W-1:0] apply_frame_command(frame_cmd_t c);
    int nc, nr, x, y, ex, ey, a;
    logic [CHAR_W-1:0] r;
    nc = active_width();
    nr = active_height();
    x = fit_coord(c.col, nc);
    y = fit_coord(c.row, nr);
    ex = fit_coord(c.col_end, nc);
    ey = fit_coord(c.row_end, nr);
    r = ccb_pkg::EMPTY_CHAR;
    case (c.op)
      ccb_pkg::OP_WRITE: begin
        a = cell_addr(x, y, nc);
        if (!lock_store[a]) glyph_store[a] = c.ch;
      end
      ccb_pkg::OP_READ_RAW: r = glyph_store[cell_addr(x, y, nc)];
      ccb_pkg::OP_READ_DISP: r = visible_char(cell_addr(x, y, nc));
      ccb_pkg::OP_FILL: begin
        for (int cy = 1; cy <= nr; cy++)
          for (int cx = 1; cx <= nc; cx++) begin
            a = cell_addr(cx, cy, nc);
            if (!lock_store[a]) glyph_store[a] = c.ch;
          end
      end
      ccb_pkg::OP_LOCK_AREA: begin
        for (int cx = x; cx <= ex; cx++)
          for (int cy = y; cy <= ey; cy++)
            lock_store[cell_addr(cx, cy, nc)] = c.lk;
      end
      ccb_pkg::OP_CAPTURE: begin
        for (int cy = 1; cy <= nr; cy++)
          for (int cx = 1; cx <= nc; cx++) begin
            a = cell_addr(cx, cy, nc);
            backdrop_store[a] = visible_char(a);
          end
      end
      ccb_pkg::OP_CLEAR: wipe_frame();
      default: ;
    endcase
    return r;
  endfunction

  // mostly in range, some edges, some raw 16-bit values
  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return COORD_W'($urandom_range(1, lim));
    if (r < 90) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return COORD_W'(1);
        2: return COORD_W'(lim);
        3: return COORD_W'(lim + 1);
        default: return '1;
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  // sweeps are rare where the active area is large
  function automatic frame_cmd_t random_frame_command();
    frame_cmd_t c;
    int nc, nr, r, sweep_w;
    nc = active_width();
    nr = active_height();
    sweep_w = (nc * nr <= 256) ? 40 : 5;
    c.col = pick_coord(nc);
    c.row = pick_coord(nr);
    c.ch = ($urandom_range(0, 99) < 15) ? ccb_pkg::EMPTY_CHAR
                                        : CHAR_W'($urandom_range(0, 255));
    c.lk = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 75) begin
      c.col_end = c.col + COORD_W'($urandom_range(0, 3));
      c.row_end = c.row + COORD_W'($urandom_range(0, 3));
    end else if (r < 90) begin
      c.col_end = COORD_W'($urandom_range(1, nc));
      c.row_end = COORD_W'($urandom_range(1, nr));
    end else begin
      c.col_end = COORD_W'($urandom);
      c.row_end = COORD_W'($urandom);
    end
    r = $urandom_range(0, 999);
    if (r < 5) c.op = ccb_pkg::OP_CLEAR;
    else if (r < 15) c.op = ccb_pkg::OP_RESERVED;
    else if (r < 15 + sweep_w) c.op = ccb_pkg::OP_FILL;
    else if (r < 15 + 2 * sweep_w) c.op = ccb_pkg::OP_CAPTURE;
    else if (r < 105 + 2 * sweep_w) c.op = ccb_pkg::OP_LOCK_AREA;
    else begin
      r = $urandom_range(0, 99);
      if (r < 40) c.op = ccb_pkg::OP_WRITE;
      else if (r < 70) c.op = ccb_pkg::OP_READ_RAW;
      else c.op = ccb_pkg::OP_READ_DISP;
    end
    return c;
  endfunction

  // offer one command word, predict its reply once it is taken
  task automatic offer_command(frame_cmd_t c, logic typed, logic [CHAR_W-1:0] want);
    frame_reply_t reply;
    logic [CHAR_W-1:0] got;
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, c.lk, c.ch, c.row_end, c.col_end, c.row, c.col, c.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = apply_frame_command(c);
    reply.ch = typed ? want : got;
    reply.op = c.op;
    pending_replies.push_back(reply);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ccb_pkg::CFG_COLUMNS) cols_setting = val;
    else rows_setting = val[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every pending reply
  task automatic drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // receiver backpressure, plus the long hold-off
  always @(negedge clk) begin
    out_tready <= !hold_results && ($urandom_range(0, 99) >= stall_pct);
  end

  initial forever begin
    @(hold_go);
    @(posedge clk);
    hold_results = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results = 1'b0;
  end

  // reply checker
  always @(posedge clk) begin
    frame_reply_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply word with nothing pending, got char %02h op %0d",
                 $time, out_tdata[7:0], out_tdata[10:8]);
        mismatches++;
      end else begin
        w = pending_replies.pop_front();
        if (out_tdata[7:0] !== w.ch) begin
          $display("%0t: char_out expected %02h, got %02h", $time, w.ch, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[10:8] !== w.op) begin
          $display("%0t: command_done expected %0d, got %0d", $time, w.op, out_tdata[10:8]);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cols_setting = ccb_pkg::COLS_RESET;
    rows_setting = ccb_pkg::ROWS_RESET;
    wipe_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    for (int i = 0; i < DIRECTED_COUNT; i++)
      offer_command(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);
    drain_replies();

    // random phases, each with its own sizes and one of four idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_register(ccb_pkg::CFG_COLUMNS, 8'(PHASE_COLS[p]));
      write_register(ccb_pkg::CFG_ROWS, 8'(PHASE_ROWS[p]));
      @(posedge clk);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      if (p == 0) -> hold_go;
      repeat (ITEMS_PER_PHASE)
        offer_command(random_frame_command(), 1'b0, ccb_pkg::EMPTY_CHAR);
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
